// File: src/fspa_pkg.sv
`timescale 1ns / 1ps

package fspa_pkg;

   // Field widths fixed by the interface.
   localparam int ADDR_W      = 64;
   localparam int OBJ_W       = 16;
   localparam int ALIGN_W     = 13;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   // Object size plus alignment minus one needs one bit more than the object size.
   localparam int STRIDE_W    = OBJ_W + 1;

   localparam int FSPA_SLOTS  = 64;

   localparam logic [ADDR_W-1:0]  POOL_BASE_RESET      = '0;
   localparam logic [OBJ_W-1:0]   OBJECT_SIZE_RESET    = 16'd64;
   localparam logic [ALIGN_W-1:0] SLOT_ALIGNMENT_RESET = 13'd8;
   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET     = 7'd64;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDRESS = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POOL_BASE      = 2'd0,
      CSR_OBJECT_SIZE    = 2'd1,
      CSR_SLOT_ALIGNMENT = 2'd2,
      CSR_SLOT_COUNT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              command;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   slot_address;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  pool_base;
      logic [OBJ_W-1:0]   object_size;
      logic [ALIGN_W-1:0] slot_alignment;
      logic [COUNT_W-1:0] slot_count;
   } cfg_type;

endpackage

// File: src/fspa_ram.sv
`timescale 1ns / 1ps

module fspa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/fspa_sdiv.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend register shifts
// left and collects the quotient bits at its low end.
module fspa_sdiv #(
   parameter int DW = 64,
   parameter int VW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] num_ff, num_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          take;

   always_comb begin
      trial   = {rem_ff, num_ff[DW-1]};
      diff    = trial - {1'b0, den_ff};
      take    = (trial >= {1'b0, den_ff});
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DW-2:0], take};
         rem_in = take ? diff[VW-1:0] : trial[VW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

// File: src/fspa_regs.sv
`timescale 1ns / 1ps

module fspa_regs import fspa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]      csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POOL_BASE:      cfg_in.pool_base      = csr_wdata;
            CSR_OBJECT_SIZE:    cfg_in.object_size    = csr_wdata[OBJ_W-1:0];
            CSR_SLOT_ALIGNMENT: cfg_in.slot_alignment = csr_wdata[ALIGN_W-1:0];
            CSR_SLOT_COUNT:     cfg_in.slot_count     = csr_wdata[COUNT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_base      <= POOL_BASE_RESET;
         cfg_ff.object_size    <= OBJECT_SIZE_RESET;
         cfg_ff.slot_alignment <= SLOT_ALIGNMENT_RESET;
         cfg_ff.slot_count     <= SLOT_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/fixed_slot_pool_allocator_unit.sv
`timescale 1ns / 1ps
// Allocate and free both open with a bit-serial stride division; allocate then scans for the
// lowest free slot, and a free with a nonzero stride adds a bit-serial division of the
// address offset. One item is in work at a time. Reset is synchronous; afterwards a clearing
// pass zeroes the busy map while req_ready stays low. Configuration writes are taken at any time.
module fixed_slot_pool_allocator_unit import fspa_pkg::*; #(
   parameter int SLOTS = FSPA_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]      csr_wdata
);

   // Slot index width, width of a slot count, compare width, and width of the product of stride and index.
   localparam int SW   = $clog2(SLOTS);
   localparam int NW   = $clog2(SLOTS + 1);
   localparam int CMPW = (NW > COUNT_W) ? NW : COUNT_W;
   localparam int PW   = STRIDE_W + SW;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_STRIDE = 8'b0000_0100,
      S_QUOT   = 8'b0000_1000,
      S_SCAN   = 8'b0001_0000,
      S_MUL    = 8'b0010_0000,
      S_SUM    = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   cfg_type cfg;

   state_type             state_ff, state_in;
   logic                  cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     off_ff, off_in;
   logic [STRIDE_W-1:0]   stride_ff, stride_in;
   logic [NW-1:0]         rd_idx_ff, rd_idx_in;
   logic [NW-1:0]         chk_idx_ff, chk_idx_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [ADDR_W-1:0]     res_addr_ff, res_addr_in;
   logic [SW-1:0]         clr_idx_ff, clr_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [ALIGN_W-1:0]    align_eff;
   logic [STRIDE_W-1:0]   stride_num;
   logic                  s_done;
   logic [ALIGN_W-1:0]    s_rem;
   logic [STRIDE_W-1:0]   stride_w;
   logic                  q_start;
   logic                  q_done;
   logic [ADDR_W-1:0]     q_quot;
   logic [STRIDE_W-1:0]   q_rem;
   logic                  q_ok;
   logic [CMPW-1:0]       count_ext;
   logic [CMPW-1:0]       count_clamp;
   logic [NW-1:0]         n_active;
   logic                  ram_we;
   logic [SW-1:0]         ram_waddr;
   logic [0:0]            ram_wdata;
   logic [0:0]            ram_rdata;

   fspa_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Configured slot count, clamped to the size of the busy map.
   assign count_ext   = CMPW'(cfg.slot_count);
   assign count_clamp = (count_ext > CMPW'(SLOTS)) ? CMPW'(SLOTS) : count_ext;
   assign n_active    = count_clamp[NW-1:0];

   // Stride is the object size rounded up to the alignment; a zero alignment acts as one.
   // It is the rounded-up numerator minus its remainder modulo the alignment.
   assign align_eff  = (cfg.slot_alignment == '0) ? ALIGN_W'(1) : cfg.slot_alignment;
   assign stride_num = {1'b0, cfg.object_size}
                     + {{(STRIDE_W - ALIGN_W){1'b0}}, align_eff} - STRIDE_W'(1);

   assign accept = req_valid && req_ready;

   fspa_sdiv #(
      .DW (STRIDE_W),
      .VW (ALIGN_W)
   ) u_stride_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (stride_num),
      .divisor   (align_eff),
      .done      (s_done),
      .quotient  (),
      .remainder (s_rem)
   );

   assign stride_w = stride_num - {{(STRIDE_W - ALIGN_W){1'b0}}, s_rem};

   // For a free, the offset division starts as soon as the stride is known and is nonzero.
   assign q_start = (state_ff == S_STRIDE) && s_done && (cmd_ff == CMD_FREE)
                 && (stride_w != '0);

   fspa_sdiv #(
      .DW (ADDR_W),
      .VW (STRIDE_W)
   ) u_offset_div (
      .clock     (clock),
      .reset     (reset),
      .start     (q_start),
      .dividend  (off_ff),
      .divisor   (stride_w),
      .done      (q_done),
      .quotient  (q_quot),
      .remainder (q_rem)
   );

   // A freed address must sit exactly on a slot start below the active slot count.
   assign q_ok = (q_rem == '0) && (q_quot[ADDR_W-1:NW] == '0) && (q_quot[NW-1:0] < n_active);

   fspa_ram #(
      .WIDTH (1),
      .DEPTH (SLOTS)
   ) u_busy_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_idx_ff[SW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      off_in        = off_ff;
      stride_in     = stride_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_valid_in  = chk_valid_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      clr_idx_in    = clr_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = chk_idx_ff[SW-1:0];
      ram_wdata     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // Sweep the busy map once, one slot per cycle.
            ram_we     = 1'b1;
            ram_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + SW'(1);
            if (clr_idx_ff == SW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_payload.command;
               off_in   = req_payload.free_address - cfg.pool_base;
               state_in = S_STRIDE;
            end
         end
         S_STRIDE: begin
            if (s_done) begin
               stride_in   = stride_w;
               res_addr_in = '0;
               if (cmd_ff == CMD_FREE) begin
                  if (stride_w == '0) begin
                     // Every slot starts at the base, so only the base frees slot zero.
                     if ((off_ff == '0) && (n_active != '0)) begin
                        ram_we        = 1'b1;
                        ram_waddr     = '0;
                        res_status_in = STATUS_OK;
                     end else begin
                        res_status_in = STATUS_BAD_ADDRESS;
                     end
                     state_in = S_RESP;
                  end else begin
                     state_in = S_QUOT;
                  end
               end else if (n_active == '0) begin
                  res_status_in = STATUS_FULL;
                  state_in      = S_RESP;
               end else begin
                  rd_idx_in    = '0;
                  chk_valid_in = 1'b0;
                  state_in     = S_SCAN;
               end
            end
         end
         S_QUOT: begin
            if (q_done) begin
               res_addr_in = '0;
               if (q_ok) begin
                  ram_we        = 1'b1;
                  ram_waddr     = q_quot[SW-1:0];
                  res_status_in = STATUS_OK;
               end else begin
                  res_status_in = STATUS_BAD_ADDRESS;
               end
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            // Reads are issued every cycle; the registered data of the previous
            // read is checked while the next one is on its way.
            rd_idx_in    = rd_idx_ff + NW'(1);
            chk_idx_in   = rd_idx_ff;
            chk_valid_in = (rd_idx_ff < n_active);
            if (chk_valid_ff) begin
               if (ram_rdata == 1'b0) begin
                  ram_we     = 1'b1;
                  ram_wdata  = 1'b1;
                  chk_idx_in = chk_idx_ff;
                  state_in   = S_MUL;
               end else if (chk_idx_ff == (n_active - NW'(1))) begin
                  res_status_in = STATUS_FULL;
                  res_addr_in   = '0;
                  state_in      = S_RESP;
               end
            end
         end
         S_MUL: begin
            prod_in  = PW'(stride_ff) * PW'(chk_idx_ff[SW-1:0]);
            state_in = S_SUM;
         end
         S_SUM: begin
            res_addr_in   = cfg.pool_base + {{(ADDR_W - PW){1'b0}}, prod_ff};
            res_status_in = STATUS_OK;
            state_in      = S_RESP;
         end
         S_RESP: begin
            // The output register frees the engine as soon as it can take the result.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = res_status_ff;
               rsp_data_in.slot_address = res_addr_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      off_ff        <= off_in;
      stride_ff     <= stride_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// File: src/fspa_checker.sv
`timescale 1ns / 1ps

module fspa_checker import fspa_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_type                rsp_payload
);

   // A result that is not taken stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // The engine works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STATUS_OK) || (rsp_payload.status == STATUS_FULL)
                 || (rsp_payload.status == STATUS_BAD_ADDRESS))
      else $error("undefined status code");

   // Failures never carry an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STATUS_OK) |-> rsp_payload.slot_address == '0)
      else $error("failed result with nonzero address");

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker (.*);
